// File: hw/rtl/lvbs_pkg.sv
// Shared types and constants of the Laplacian variance blur score block.
package lvbs_pkg;

	localparam int GRAY_W     = 8;
	localparam int LAP_W      = 11;
	localparam int SQR_W      = 20;
	localparam int CNT_W      = 26;
	localparam int SUM_W      = 37;
	localparam int SQ_W       = 47;
	localparam int MAG_W      = 36;
	localparam int POS_W      = 14;
	localparam int VAR_W      = 28;
	localparam int PCNT_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int HCFG_W     = 12;
	localparam int VCFG_W     = 13;

	localparam logic [VAR_W-1:0] VAR_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_CROP_LEFT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CROP_TOP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CROP_RIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CROP_BOTTOM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd5;

	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic proc;
		logic latch;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic frame_end;
	} dp_status_t;

endpackage

// File: hw/rtl/laplacian_variance_blur_score_core.sv
// Top level of the Laplacian variance blur score block.
//
//  channel  signals                                  direction
//  pixel    in_valid/in_ready, blue green red frame_start   in
//  score    out_valid/out_ready, variance_q8 region_valid point_count  out
//  config   cfg_we, cfg_index, cfg_data                  in
//
// A pixel word is taken in the idle state, where the two gray line stores are
// read at its column; the next state forms the Laplacian and writes the stores
// back, and no new pixel is taken before it ends. At the last pixel of a frame
// the score is formed by the shared 26x26 multiplier (six products) and the
// 82-step restoring division. After reset a clearing pass zeroes every column
// of the line stores; no pixel is taken until it ends.
// A score word waits in its output register; no pixel is taken while a frame's
// score is formed or while a new score waits for the previous one to be taken.
module laplacian_variance_blur_score_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          blue,
	input  logic [7:0]                          green,
	input  logic [7:0]                          red,
	input  logic                                frame_start,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lvbs_pkg::VAR_W-1:0]          variance_q8,
	output logic                                region_valid,
	output logic [lvbs_pkg::PCNT_W-1:0]         point_count,
	input  logic                                cfg_we,
	input  logic [lvbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lvbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	lvbs_pkg::dp_cmd_t                  cmd;
	lvbs_pkg::dp_status_t               st;
	logic                               unit_done;
	logic [lvbs_pkg::VAR_W-1:0]         unit_result;
	logic signed [lvbs_pkg::SUM_W-1:0]  sum_w;
	logic [lvbs_pkg::SQ_W-1:0]          sq_w;
	logic [lvbs_pkg::CNT_W-1:0]         cnt_w;

	lvbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.unit_done (unit_done),
		.cmd       (cmd)
	);

	lvbs_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.frame_start  (frame_start),
		.cmd          (cmd),
		.st           (st),
		.sum_out      (sum_w),
		.sq_out       (sq_w),
		.cnt_out      (cnt_w),
		.unit_result  (unit_result),
		.variance_q8  (variance_q8),
		.region_valid (region_valid),
		.point_count  (point_count)
	);

	lvbs_var_unit u_var (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.latch),
		.sum_in (sum_w),
		.sq_in  (sq_w),
		.cnt_in (cnt_w),
		.done   (unit_done),
		.result (unit_result)
	);

endmodule

// File: hw/rtl/lvbs_ctrl.sv
// Controller state machine of the blur score block.
module lvbs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  lvbs_pkg::dp_status_t  st,
	input  logic                  unit_done,
	output lvbs_pkg::dp_cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PROC,
		S_FEND,
		S_START,
		S_WAIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.clr_wr   = (state_q == S_CLEAR);
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.proc     = (state_q == S_PROC);
		cmd.latch    = (state_q == S_START);
		cmd.load_out = (state_q == S_WAIT) && unit_done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (st.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PROC;
					end
				end
				S_PROC: begin
					state_q <= st.frame_end ? S_FEND : S_IDLE;
				end
				// The last point's accumulation lands during this cycle.
				S_FEND: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (unit_done && out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("pending result word dropped");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_START |=> !unit_done)
		else $error("variance unit did not restart at frame end");

	a_fend_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROC && st.frame_end |=> !in_ready)
		else $error("input accepted before frame result was formed");

endmodule

// File: hw/rtl/lvbs_datapath.sv
// Datapath: configuration, gray line stores, Laplacian, sums and result word.
module lvbs_datapath #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [lvbs_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [lvbs_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic [7:0]                               blue,
	input  logic [7:0]                               green,
	input  logic [7:0]                               red,
	input  logic                                     frame_start,
	input  lvbs_pkg::dp_cmd_t                        cmd,
	output lvbs_pkg::dp_status_t                     st,
	output logic signed [lvbs_pkg::SUM_W-1:0]        sum_out,
	output logic [lvbs_pkg::SQ_W-1:0]                sq_out,
	output logic [lvbs_pkg::CNT_W-1:0]               cnt_out,
	input  logic [lvbs_pkg::VAR_W-1:0]               unit_result,
	output logic [lvbs_pkg::VAR_W-1:0]               variance_q8,
	output logic                                     region_valid,
	output logic [lvbs_pkg::PCNT_W-1:0]              point_count
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam logic [lvbs_pkg::POS_W-1:0] MAXW_C = lvbs_pkg::POS_W'(MAX_WIDTH);
	localparam logic [lvbs_pkg::POS_W-1:0] MAXH_C = lvbs_pkg::POS_W'(MAX_HEIGHT);
	localparam logic [AW-1:0] CLR_LAST_C = AW'(MAX_WIDTH - 1);
	localparam int GW = lvbs_pkg::GRAY_W;
	localparam int PW = lvbs_pkg::POS_W;

	logic [lvbs_pkg::HCFG_W-1:0] crop_left_q, crop_right_q, image_width_q;
	logic [lvbs_pkg::VCFG_W-1:0] crop_top_q, crop_bottom_q, image_height_q;

	logic [GW-1:0] prev_mem [MAX_WIDTH];
	logic [GW-1:0] old_mem  [MAX_WIDTH];
	logic [GW-1:0] rd_prev_s1, rd_old_s1;

	logic [AW-1:0] clr_cnt_q;
	logic [AW-1:0] col_q, c_s1, c_acc;
	logic [RW-1:0] row_q, r_s1, r_acc;
	logic [GW-1:0] g_s1;
	logic [GW-1:0] win_q, glast_q, pn1_q, pn2_q;
	logic [9:0]    rgb_sum;

	logic signed [lvbs_pkg::LAP_W-1:0] lap_s2;
	logic                              acc_en_s2;

	logic signed [lvbs_pkg::SUM_W-1:0] sum_q;
	logic [lvbs_pkg::SQ_W-1:0]         sq_q;
	logic [lvbs_pkg::CNT_W-1:0]        cnt_q;
	logic                              ok_q;
	logic [lvbs_pkg::PCNT_W-1:0]       pcnt_q;

	logic [PW-1:0] ew, eh, rx, by, iw, ih, cl, ct, cr, cb, c14, r14;
	logic          box_ok, pt, col_end, row_end, sum_clr;
	logic [9:0]    nb_sum;
	logic signed [11:0] lap12;
	logic signed [2*lvbs_pkg::LAP_W-1:0] lap_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_left_q    <= '0;
			crop_top_q     <= '0;
			crop_right_q   <= 12'd2048;
			crop_bottom_q  <= 13'd4096;
			image_width_q  <= 12'd2048;
			image_height_q <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				lvbs_pkg::CFG_CROP_LEFT:    crop_left_q    <= cfg_data[lvbs_pkg::HCFG_W-1:0];
				lvbs_pkg::CFG_CROP_TOP:     crop_top_q     <= cfg_data[lvbs_pkg::VCFG_W-1:0];
				lvbs_pkg::CFG_CROP_RIGHT:   crop_right_q   <= cfg_data[lvbs_pkg::HCFG_W-1:0];
				lvbs_pkg::CFG_CROP_BOTTOM:  crop_bottom_q  <= cfg_data[lvbs_pkg::VCFG_W-1:0];
				lvbs_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[lvbs_pkg::HCFG_W-1:0];
				lvbs_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[lvbs_pkg::VCFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective frame size and crop box clamped to it.
	always_comb begin
		iw = PW'(image_width_q);
		ih = PW'(image_height_q);
		cl = PW'(crop_left_q);
		ct = PW'(crop_top_q);
		cr = PW'(crop_right_q);
		cb = PW'(crop_bottom_q);
		ew = (iw == '0) ? PW'(1) : ((iw > MAXW_C) ? MAXW_C : iw);
		eh = (ih == '0) ? PW'(1) : ((ih > MAXH_C) ? MAXH_C : ih);
		rx = (cr < ew) ? cr : ew;
		by = (cb < eh) ? cb : eh;
		box_ok = (rx > cl + PW'(4)) && (by > ct + PW'(4));
		c14 = PW'(c_s1);
		r14 = PW'(r_s1);
		pt = (c14 >= PW'(2)) && (r14 >= PW'(2)) && box_ok
			&& (c14 >= cl + PW'(2)) && (c14 < rx)
			&& (r14 >= ct + PW'(2)) && (r14 < by);
		col_end = (c14 + PW'(1) >= ew);
		row_end = (r14 + PW'(1) >= eh);
	end

	assign st.clr_last  = (clr_cnt_q == CLR_LAST_C);
	assign st.frame_end = col_end && row_end;

	assign rgb_sum = 10'(blue) + {1'b0, green, 1'b0} + 10'(red);
	assign c_acc   = frame_start ? '0 : col_q;
	assign r_acc   = frame_start ? '0 : row_q;

	// The neighbors of the point one column left and one row up come from the
	// values read at the two previous columns, so only column c is read here.
	always_comb begin
		nb_sum = 10'(win_q) + 10'(glast_q) + 10'(pn2_q) + 10'(rd_prev_s1);
		lap12  = $signed({2'b00, nb_sum}) - $signed({2'b00, pn1_q, 2'b00});
		lap_sq = lap_s2 * lap_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_prev_s1 <= prev_mem[c_acc];
			rd_old_s1  <= old_mem[c_acc];
		end
		if (cmd.clr_wr) begin
			prev_mem[clr_cnt_q] <= '0;
			old_mem[clr_cnt_q]  <= '0;
		end else if (cmd.proc) begin
			prev_mem[c_s1] <= g_s1;
			old_mem[c_s1]  <= rd_prev_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			g_s1 <= rgb_sum[9:2];
		end
		if (cmd.proc) begin
			win_q   <= rd_old_s1;
			glast_q <= g_s1;
			pn2_q   <= pn1_q;
			pn1_q   <= rd_prev_s1;
			lap_s2  <= lap12[lvbs_pkg::LAP_W-1:0];
		end
		if (cmd.latch) begin
			ok_q   <= box_ok && (cnt_q != '0);
			pcnt_q <= cnt_q[lvbs_pkg::PCNT_W-1:0];
		end
		if (cmd.load_out) begin
			variance_q8  <= ok_q ? unit_result : '0;
			region_valid <= ok_q;
			point_count  <= pcnt_q;
		end
	end

	assign sum_clr = (cmd.accept && frame_start) || cmd.latch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			c_s1      <= '0;
			r_s1      <= '0;
			acc_en_s2 <= 1'b0;
			sum_q     <= '0;
			sq_q      <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.accept) begin
				c_s1 <= c_acc;
				r_s1 <= r_acc;
			end
			if (cmd.proc) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : r_s1 + RW'(1);
				end else begin
					col_q <= c_s1 + AW'(1);
					row_q <= r_s1;
				end
			end
			acc_en_s2 <= cmd.proc && pt;
			// A clear in the same cycle as an accumulation follows it in order.
			if (sum_clr) begin
				sum_q <= '0;
				sq_q  <= '0;
				cnt_q <= '0;
			end else if (acc_en_s2) begin
				sum_q <= sum_q + {{(lvbs_pkg::SUM_W-lvbs_pkg::LAP_W){lap_s2[lvbs_pkg::LAP_W-1]}},
					lap_s2};
				sq_q  <= sq_q + lvbs_pkg::SQ_W'(lap_sq[lvbs_pkg::SQR_W-1:0]);
				cnt_q <= cnt_q + lvbs_pkg::CNT_W'(1);
			end
		end
	end

	assign sum_out = sum_q;
	assign sq_out  = sq_q;
	assign cnt_out = cnt_q;

endmodule

// File: hw/rtl/lvbs_var_unit.sv
// Iterative frame-end unit: floor(256*(n*sumsq - sum^2)/n^2) with saturation.
module lvbs_var_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [lvbs_pkg::SUM_W-1:0]  sum_in,
	input  logic [lvbs_pkg::SQ_W-1:0]          sq_in,
	input  logic [lvbs_pkg::CNT_W-1:0]         cnt_in,
	output logic                               done,
	output logic [lvbs_pkg::VAR_W-1:0]         result
);

	localparam int OPW   = 26;
	localparam int PRW   = 2 * OPW;
	localparam int ACW   = 74;
	localparam int NUMW  = ACW + 8;
	localparam int MAG_H = 18;
	localparam int SQ_H  = 24;
	localparam logic [6:0] DIV_LAST = 7'(NUMW - 1);

	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL,
		U_SUB,
		U_DIV,
		U_DONE
	} ustate_t;

	typedef enum logic [2:0] {
		P_N_SQ_LO,
		P_N_SQ_HI,
		P_M_LO_LO,
		P_M_LO_HI,
		P_M_HI_HI,
		P_N_N,
		P_END
	} step_t;

	ustate_t state_q;
	step_t   step_q, ptag_q;
	logic    pvalid_q;

	logic [lvbs_pkg::CNT_W-1:0] n_q;
	logic [lvbs_pkg::SQ_W-1:0]  sq_q;
	logic [lvbs_pkg::MAG_W-1:0] mag_q;
	logic [OPW-1:0]             opa, opb;
	logic [PRW-1:0]             prod_q;
	logic [ACW-1:0]             acc_a_q, acc_b_q, prod_ext;
	logic [PRW-1:0]             div_q;
	logic [NUMW-1:0]            num_q;
	logic [PRW-1:0]             rem_q;
	logic [PRW:0]               rem_sh, rem_sub;
	logic                       ge;
	logic [lvbs_pkg::VAR_W-1:0] quo_q;
	logic                       ovf_q, neg_q;
	logic [6:0]                 bit_q;
	logic [lvbs_pkg::SUM_W-1:0] sum_abs;

	assign sum_abs = sum_in[lvbs_pkg::SUM_W-1] ? -sum_in : sum_in;

	always_comb begin
		case (step_q)
			P_N_SQ_LO: begin
				opa = OPW'(n_q);
				opb = OPW'(sq_q[SQ_H-1:0]);
			end
			P_N_SQ_HI: begin
				opa = OPW'(n_q);
				opb = OPW'(sq_q[lvbs_pkg::SQ_W-1:SQ_H]);
			end
			P_M_LO_LO: begin
				opa = OPW'(mag_q[MAG_H-1:0]);
				opb = OPW'(mag_q[MAG_H-1:0]);
			end
			P_M_LO_HI: begin
				opa = OPW'(mag_q[MAG_H-1:0]);
				opb = OPW'(mag_q[lvbs_pkg::MAG_W-1:MAG_H]);
			end
			P_M_HI_HI: begin
				opa = OPW'(mag_q[lvbs_pkg::MAG_W-1:MAG_H]);
				opb = OPW'(mag_q[lvbs_pkg::MAG_W-1:MAG_H]);
			end
			P_N_N: begin
				opa = OPW'(n_q);
				opb = OPW'(n_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		prod_ext = ACW'(prod_q);
		rem_sh   = {rem_q, num_q[NUMW-1]};
		rem_sub  = rem_sh - {1'b0, div_q};
		ge       = (rem_sh >= {1'b0, div_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= cnt_in;
			sq_q  <= sq_in;
			mag_q <= sum_abs[lvbs_pkg::MAG_W-1:0];
		end
		prod_q <= opa * opb;
		ptag_q <= step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= U_IDLE;
			step_q   <= P_N_SQ_LO;
			pvalid_q <= 1'b0;
			acc_a_q  <= '0;
			acc_b_q  <= '0;
			div_q    <= '0;
			num_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			ovf_q    <= 1'b0;
			neg_q    <= 1'b0;
			bit_q    <= '0;
		end else begin
			pvalid_q <= (state_q == U_MUL) && (step_q != P_END);
			if (pvalid_q) begin
				case (ptag_q)
					P_N_SQ_LO: acc_a_q <= acc_a_q + prod_ext;
					P_N_SQ_HI: acc_a_q <= acc_a_q + (prod_ext << SQ_H);
					P_M_LO_LO: acc_b_q <= acc_b_q + prod_ext;
					P_M_LO_HI: acc_b_q <= acc_b_q + (prod_ext << (MAG_H + 1));
					P_M_HI_HI: acc_b_q <= acc_b_q + (prod_ext << (2 * MAG_H));
					P_N_N:     div_q   <= prod_q;
					default: begin
					end
				endcase
			end
			if (start) begin
				state_q <= U_MUL;
				step_q  <= P_N_SQ_LO;
				acc_a_q <= '0;
				acc_b_q <= '0;
			end else begin
				case (state_q)
					U_MUL: begin
						// The last product is accumulated in the cycle that ends this state.
						if (step_q == P_END) begin
							state_q <= U_SUB;
						end else begin
							step_q <= step_t'(step_q + 3'd1);
						end
					end
					U_SUB: begin
						neg_q   <= (acc_a_q < acc_b_q);
						num_q   <= {acc_a_q - acc_b_q, 8'd0};
						rem_q   <= '0;
						quo_q   <= '0;
						ovf_q   <= 1'b0;
						bit_q   <= DIV_LAST;
						state_q <= U_DIV;
					end
					U_DIV: begin
						rem_q <= ge ? rem_sub[PRW-1:0] : rem_sh[PRW-1:0];
						num_q <= num_q << 1;
						quo_q <= {quo_q[lvbs_pkg::VAR_W-2:0], ge};
						ovf_q <= ovf_q || quo_q[lvbs_pkg::VAR_W-1];
						bit_q <= bit_q - 7'd1;
						if (bit_q == '0) begin
							state_q <= U_DONE;
						end
					end
					U_IDLE, U_DONE: begin
					end
					default: begin
						state_q <= U_IDLE;
					end
				endcase
			end
		end
	end

	assign done   = (state_q == U_DONE);
	assign result = neg_q ? '0 : (ovf_q ? lvbs_pkg::VAR_MAX : quo_q);

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == U_SUB && n_q != '0 |=> div_q != '0)
		else $error("divisor lost before division");

	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(state_q) == U_DIV)
		else $error("result flagged without a division pass");

	a_neg_impossible: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !neg_q)
		else $error("n*sumsq fell below sum squared");

endmodule

// File: dv/lvbs_score_checker.sv
// Checker that predicts and compares the score words of the blur score block.
`timescale 1ns / 100ps

module lvbs_score_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [7:0]                        blue,
	input  logic [7:0]                        green,
	input  logic [7:0]                        red,
	input  logic                              frame_start,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [lvbs_pkg::VAR_W-1:0]        variance_q8,
	input  logic                              region_valid,
	input  logic [lvbs_pkg::PCNT_W-1:0]       point_count,
	input  logic                              cfg_we,
	input  logic [lvbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lvbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                fail_count,
	output int                                scores_pending
);

	localparam int LINE_LEN   = 2048;
	localparam int FRAME_ROWS = 4096;
	localparam int HW         = lvbs_pkg::HCFG_W;
	localparam int VW         = lvbs_pkg::VCFG_W;
	localparam int VW_OUT     = lvbs_pkg::VAR_W;
	localparam int CW_OUT     = lvbs_pkg::PCNT_W;

	typedef struct {
		logic [VW_OUT-1:0] variance;
		logic              valid;
		logic [CW_OUT-1:0] count;
	} score_t;

	score_t pending_scores[$];

	logic [HW-1:0] crop_left, crop_right, image_width;
	logic [VW-1:0] crop_top, crop_bottom, image_height;
	logic [7:0] line_prev[LINE_LEN];
	logic [7:0] line_older[LINE_LEN];
	logic [7:0] up_left;
	int unsigned col, row;
	longint lap_sum;
	longint unsigned sq_sum;
	longint unsigned n_points;

	function automatic logic [VW_OUT-1:0] q8_variance(longint s, longint unsigned s2,
			longint unsigned n);
		logic [127:0] lhs, rhs, quot;
		longint unsigned mag;
		mag = (s < 0) ? longint'(-s) : longint'(s);
		lhs = 128'(n) * 128'(s2);
		rhs = 128'(mag) * 128'(mag);
		if (lhs < rhs)
			return '0;
		quot = ((lhs - rhs) << 8) / (128'(n) * 128'(n));
		if (quot > 128'(lvbs_pkg::VAR_MAX))
			return lvbs_pkg::VAR_MAX;
		return quot[VW_OUT-1:0];
	endfunction

	task automatic advance_raster(input logic [7:0] b, input logic [7:0] g8,
			input logic [7:0] r8, input logic fs);
		int gray, ew, eh, rx, by, c, r, up_now, prev_now, lap;
		bit box_ok;
		score_t sc;
		gray = (int'(b) + 2 * int'(g8) + int'(r8)) >> 2;
		if (fs) begin
			col = 0;
			row = 0;
			lap_sum = 0;
			sq_sum = 0;
			n_points = 0;
		end
		ew = (image_width == 0) ? 1 : ((image_width > LINE_LEN) ? LINE_LEN : int'(image_width));
		eh = (image_height == 0) ? 1 :
			((image_height > FRAME_ROWS) ? FRAME_ROWS : int'(image_height));
		rx = (crop_right < ew) ? int'(crop_right) : ew;
		by = (crop_bottom < eh) ? int'(crop_bottom) : eh;
		box_ok = (rx > int'(crop_left) + 4) && (by > int'(crop_top) + 4);
		c = col % LINE_LEN;
		r = row;
		up_now = line_older[c];
		prev_now = line_prev[c];
		line_older[c] = prev_now[7:0];
		line_prev[c] = gray[7:0];
		// The window is centered one column and one row behind the incoming pixel.
		if (c >= 2 && r >= 2 && box_ok) begin
			if (c - 1 >= int'(crop_left) + 1 && c < rx && r - 1 >= int'(crop_top) + 1
					&& r < by) begin
				lap = int'(up_left) + int'(line_prev[c-1]) + int'(line_older[c-2]) + prev_now
					- 4 * int'(line_older[c-1]);
				lap_sum += lap;
				sq_sum += longint'(lap * lap);
				n_points++;
			end
		end
		up_left = up_now[7:0];
		if (c + 1 >= ew) begin
			col = 0;
			if (r + 1 >= eh) begin
				sc.valid = box_ok && n_points > 0;
				sc.variance = sc.valid ? q8_variance(lap_sum, sq_sum, n_points) : '0;
				sc.count = n_points[CW_OUT-1:0];
				pending_scores.push_back(sc);
				row = 0;
				lap_sum = 0;
				sq_sum = 0;
				n_points = 0;
			end else begin
				row = r + 1;
			end
		end else begin
			col = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		score_t want;
		if (!arst_n) begin
			crop_left = '0;
			crop_top = '0;
			crop_right = HW'(LINE_LEN);
			crop_bottom = VW'(FRAME_ROWS);
			image_width = HW'(LINE_LEN);
			image_height = VW'(FRAME_ROWS);
			for (int i = 0; i < LINE_LEN; i++) begin
				line_prev[i] = '0;
				line_older[i] = '0;
			end
			up_left = '0;
			col = 0;
			row = 0;
			lap_sum = 0;
			sq_sum = 0;
			n_points = 0;
			pending_scores.delete();
			fail_count = 0;
			scores_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lvbs_pkg::CFG_CROP_LEFT:    crop_left = cfg_data[HW-1:0];
					lvbs_pkg::CFG_CROP_TOP:     crop_top = cfg_data[VW-1:0];
					lvbs_pkg::CFG_CROP_RIGHT:   crop_right = cfg_data[HW-1:0];
					lvbs_pkg::CFG_CROP_BOTTOM:  crop_bottom = cfg_data[VW-1:0];
					lvbs_pkg::CFG_IMAGE_WIDTH:  image_width = cfg_data[HW-1:0];
					lvbs_pkg::CFG_IMAGE_HEIGHT: image_height = cfg_data[VW-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				advance_raster(blue, green, red, frame_start);
			if (out_valid && out_ready) begin
				if (pending_scores.size() == 0) begin
					$display("%0t: unexpected score word: variance %0d valid %0d count %0d",
						$realtime, variance_q8, region_valid, point_count);
					fail_count++;
				end else begin
					want = pending_scores.pop_front();
					if (variance_q8 !== want.variance) begin
						$display("%0t: variance_q8 expected %0d actual %0d", $realtime,
							want.variance, variance_q8);
						fail_count++;
					end
					if (region_valid !== want.valid) begin
						$display("%0t: region_valid expected %0d actual %0d", $realtime,
							want.valid, region_valid);
						fail_count++;
					end
					if (point_count !== want.count) begin
						$display("%0t: point_count expected %0d actual %0d", $realtime,
							want.count, point_count);
						fail_count++;
					end
				end
			end
			scores_pending = pending_scores.size();
		end
	end

endmodule

// File: dv/laplacian_variance_blur_score_core_tb.sv
// Stimulus and verdict for the Laplacian variance blur score block.
`timescale 1ns / 100ps

module laplacian_variance_blur_score_core_tb;

	localparam int DW = lvbs_pkg::CFG_DATA_W;
	localparam int IW = lvbs_pkg::CFG_IDX_W;
	localparam logic [IW-1:0] CFG_SPARE = 3'd6;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PIXEL_TARGET = 700;

	typedef enum int {PIX_RANDOM, PIX_CHECKER, PIX_EXTREME, PIX_FLAT} pix_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_ready, frame_start, out_valid, out_ready, region_valid, cfg_we;
	logic [7:0] blue, green, red;
	logic [lvbs_pkg::VAR_W-1:0] variance_q8;
	logic [lvbs_pkg::PCNT_W-1:0] point_count;
	logic [IW-1:0] cfg_index;
	logic [DW-1:0] cfg_data;
	int fail_count, scores_pending;
	int pixels_sent = 0;
	int burst_left = 0;
	int cycles = 0;
	int stall_left = 0;
	int stall_mode = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	laplacian_variance_blur_score_core u_dut (.*);

	lvbs_score_checker u_checker (.*);

	initial begin
		in_valid <= 1'b0;
		blue <= '0;
		green <= '0;
		red <= '0;
		frame_start <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Score side: segments of steady acceptance, random stalls and long stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(1, 40);
			end
			stall_left--;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= (stall_left % 16 == 0);
			endcase
		end
	end

	task automatic push_pixel(input logic [7:0] b, input logic [7:0] g8, input logic [7:0] r8,
			input logic fs);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		blue <= b;
		green <= g8;
		red <= r8;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		pixels_sent++;
	endtask

	task automatic send_frame(input int w, input int h, input pix_kind_t kind, input bit fs,
			input int npix, input bit restarts);
		logic [7:0] b, g8, r8, lvl;
		int k;
		k = 0;
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				if (k >= npix)
					return;
				lvl = ((x + y) % 2 == 1) ? 8'hFF : 8'h00;
				case (kind)
					PIX_CHECKER: begin b = lvl; g8 = lvl; r8 = lvl; end
					PIX_EXTREME: begin
						b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						g8 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						r8 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					PIX_FLAT: begin b = 8'h80; g8 = 8'h7F; r8 = 8'h81; end
					default: begin b = 8'($urandom); g8 = 8'($urandom); r8 = 8'($urandom); end
				endcase
				push_pixel(b, g8, r8, (k == 0 && fs) || (restarts && $urandom_range(0, 39) == 0));
				k++;
			end
		end
	endtask

	// Lets the block finish every score and any pixel still in flight.
	task automatic settle();
		in_valid <= 1'b0;
		frame_start <= 1'b0;
		@(negedge clk);
		while (scores_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int cl, input int ct, input int cr, input int cb,
			input int iw, input int ih, input int frames, input pix_kind_t kind);
		logic [DW-1:0] vals[7];
		logic [IW-1:0] idx[7];
		int ew, eh;
		idx = '{lvbs_pkg::CFG_CROP_LEFT, lvbs_pkg::CFG_CROP_TOP, lvbs_pkg::CFG_CROP_RIGHT,
			lvbs_pkg::CFG_CROP_BOTTOM, lvbs_pkg::CFG_IMAGE_WIDTH, lvbs_pkg::CFG_IMAGE_HEIGHT,
			CFG_SPARE};
		vals = '{DW'(cl), DW'(ct), DW'(cr), DW'(cb), DW'(iw), DW'(ih), DW'($urandom)};
		settle();
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		ew = iw % 4096;
		ew = (ew == 0) ? 1 : ((ew > 2048) ? 2048 : ew);
		eh = ih % 8192;
		eh = (eh == 0) ? 1 : ((eh > 4096) ? 4096 : eh);
		for (int f = 0; f < frames; f++)
			send_frame(ew, eh, kind, f == 0, ew * eh, 1'b0);
	endtask

	initial begin
		int iw, ih, cr, cb;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_phase(0, 0, 2048, 4096, 5, 5, 1, PIX_CHECKER);
		// A width of zero makes every pixel a whole frame.
		run_phase(0, 0, 2048, 4096, 4096, 1, 6, PIX_EXTREME);
		run_phase(0, 0, 2048, 4096, 9, 3, 1, PIX_CHECKER);
		run_phase(1, 1, 4095, 8191, 10, 6, 1, PIX_EXTREME);
		run_phase(0, 0, 1, 8191, 1, 12, 1, PIX_RANDOM);
		run_phase(2048, 4096, 0, 0, 6, 6, 1, PIX_RANDOM);
		run_phase(4095, 8191, 8, 8, 8, 8, 1, PIX_FLAT);
		run_phase(0, 0, 6, 6, 6, 0, 2, PIX_RANDOM);

		while (pixels_sent < PIXEL_TARGET) begin
			iw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
			ih = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
			cr = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, iw + 3);
			cb = ($urandom_range(0, 7) == 0) ? 8191 : $urandom_range(0, ih + 3);
			run_phase($urandom_range(0, iw), $urandom_range(0, ih), cr, cb, iw, ih,
				$urandom_range(0, 2), pix_kind_t'($urandom_range(0, 3)));
			if (iw == 0) iw = 1;
			if (ih == 0) ih = 1;
			// Random frames, some restarted early, and now and then a cut-off one
			// that the next size change leaves behind.
			repeat ($urandom_range(1, 3))
				send_frame(iw, ih, pix_kind_t'($urandom_range(0, 3)), $urandom_range(0, 1),
					iw * ih, 1'b1);
			if ($urandom_range(0, 3) == 0)
				send_frame(iw, ih, PIX_RANDOM, 1'b0, $urandom_range(1, iw * ih), 1'b0);
		end

		settle();
		if (fail_count == 0 && scores_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
